// File: src/vhnt_pkg.sv
// Shared types, constants and helpers for the voxel hull neighbor tracker.
// No dependencies; the step unit and the top level import this package.
package vhnt_pkg;

   localparam int COORD_W = 5;
   localparam int CELL_W  = 4;
   localparam int ADDR_W  = 3 * COORD_W;

   // grid size per axis, compared against coordinates zero-extended to 8 bits
   localparam logic [7:0] DIM_X = 8'd30;
   localparam logic [7:0] DIM_Y = 8'd30;
   localparam logic [7:0] DIM_Z = 8'd30;

   localparam logic [2:0] FULL_CNT = 3'd6;
   localparam logic [2:0] HULL_CNT = 3'd5;
   localparam logic [2:0] LAST_NBR = 3'd5;

   typedef logic [COORD_W-1:0] coord_type;
   typedef logic [CELL_W-1:0]  cell_type;
   typedef logic [ADDR_W-1:0]  addr_type;

   typedef enum logic [1:0] {
      FUNC_ADD    = 2'd0,
      FUNC_REMOVE = 2'd1,
      FUNC_QUERY  = 2'd2,
      FUNC_NOP    = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      KIND_HULL  = 2'd0,
      KIND_OBSC  = 2'd1,
      KIND_QUERY = 2'd2,
      KIND_DONE  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_ALREADY = 2'd1,
      STAT_NOT_SET = 2'd2,
      STAT_RANGE   = 2'd3
   } status_type;

   // neighbor coordinate from the shared step unit
   typedef struct packed {
      logic      in_grid;
      coord_type x;
      coord_type y;
      coord_type z;
   } nbr_type;

   // neighbor cell update from the shared step unit
   typedef struct packed {
      cell_type new_cell;
      logic     report;
      kind_type kind;
   } upd_type;

   function automatic addr_type cell_addr(coord_type x, coord_type y, coord_type z);
      return {z, y, x};
   endfunction

endpackage

// File: src/vhnt_cell_ram.sv
// Single-port cell store with registered read data.
// Depends on nothing; widths come from its parameters.
module vhnt_cell_ram #(
   parameter int ADDR_W = 15,
   parameter int DATA_W = 4
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] addr,
   input  logic [DATA_W-1:0] wdata,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem_ff [0:(1 << ADDR_W)-1];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// File: src/vhnt_step_unit.sv
// Shared step unit: neighbor coordinate for one face and the count update
// of that neighbor's cell. Depends on vhnt_pkg.
module vhnt_step_unit
   import vhnt_pkg::*;
(
   input  coord_type  base_x,
   input  coord_type  base_y,
   input  coord_type  base_z,
   input  logic [2:0] nbr_idx,
   input  logic       adding,
   input  cell_type   cell_in,
   output nbr_type    nbr,
   output upd_type    upd
);

   logic [7:0] ext_x;
   logic [7:0] ext_y;
   logic [7:0] ext_z;
   logic [2:0] cnt;
   logic [2:0] cnt_new;
   logic       is_set;

   assign ext_x = {3'b000, base_x};
   assign ext_y = {3'b000, base_y};
   assign ext_z = {3'b000, base_z};

   // face order: +x, -x, +y, -y, +z, -z
   always_comb begin
      nbr.in_grid = 1'b0;
      nbr.x       = base_x;
      nbr.y       = base_y;
      nbr.z       = base_z;
      unique case (nbr_idx)
         3'd0: begin
            nbr.in_grid = (ext_x + 8'd1) < DIM_X;
            nbr.x       = base_x + 5'd1;
         end
         3'd1: begin
            nbr.in_grid = (base_x != '0);
            nbr.x       = base_x - 5'd1;
         end
         3'd2: begin
            nbr.in_grid = (ext_y + 8'd1) < DIM_Y;
            nbr.y       = base_y + 5'd1;
         end
         3'd3: begin
            nbr.in_grid = (base_y != '0);
            nbr.y       = base_y - 5'd1;
         end
         3'd4: begin
            nbr.in_grid = (ext_z + 8'd1) < DIM_Z;
            nbr.z       = base_z + 5'd1;
         end
         3'd5: begin
            nbr.in_grid = (base_z != '0);
            nbr.z       = base_z - 5'd1;
         end
         default: begin
            nbr.in_grid = 1'b0;
         end
      endcase
   end

   // saturating count step, then report a set cell crossing the full mark
   always_comb begin
      cnt    = cell_in[2:0];
      is_set = cell_in[3];
      if (adding) begin
         cnt_new = (cnt < FULL_CNT) ? cnt + 3'd1 : FULL_CNT;
      end else begin
         cnt_new = (cnt != 3'd0) ? cnt - 3'd1 : 3'd0;
      end
      upd.new_cell = {is_set, cnt_new};
      upd.kind     = adding ? KIND_OBSC : KIND_HULL;
      upd.report   = is_set && (adding ? (cnt_new == FULL_CNT) : (cnt_new == HULL_CNT));
   end

endmodule

// File: src/voxel_hull_neighbor_tracker.sv
// Top level of the voxel hull neighbor tracker: command sequencer around
// the cell store and the shared step unit. Depends on vhnt_pkg,
// vhnt_cell_ram and vhnt_step_unit.
//
// Usage
//   Input: drive req_func and req_pos_x/y/z and raise start; the item is
//   taken at the clock edge where start is high and busy is low. busy stays
//   high while the item is worked on.
//   Output: each result item appears for exactly one cycle with rsp_strobe
//   high. The receiver cannot stall; results are never held.
//   Every item ends with a done result (rsp_kind done, rsp_last high).
// Sequence
//   The cell store has a single port with registered read data, so each
//   neighbor inside the grid takes a read state and a write-back state,
//   and a face on the grid edge takes only the read state. An add goes
//   through self read, self evaluation, the neighbor pass and self hull
//   to done; a remove skips self hull. An add of a set voxel, a remove
//   of a clear one and a query end after self evaluation; an out-of-range
//   or no-op item goes straight to done. Results trail their state by one register.
// Reset
//   Synchronous reset starts a clearing pass that writes zero to all 32768
//   cells, one per cycle; busy stays high for the whole pass.
module voxel_hull_neighbor_tracker
   import vhnt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_func,
   input  logic [4:0] req_pos_x,
   input  logic [4:0] req_pos_y,
   input  logic [4:0] req_pos_z,
   output logic       rsp_strobe,
   output logic [1:0] rsp_kind,
   output logic [4:0] rsp_out_x,
   output logic [4:0] rsp_out_y,
   output logic [4:0] rsp_out_z,
   output logic       rsp_hull_flag,
   output logic [1:0] rsp_status,
   output logic       rsp_last
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SELF_RD,
      ST_SELF_EVAL,
      ST_NB_RD,
      ST_NB_WB,
      ST_SELF_HULL,
      ST_DONE
   } state_type;

   state_type  state_ff, state_in;
   addr_type   clr_addr_ff, clr_addr_in;
   func_type   func_ff, func_in;
   coord_type  x_ff, x_in;
   coord_type  y_ff, y_in;
   coord_type  z_ff, z_in;
   status_type status_ff, status_in;
   cell_type   self_cell_ff, self_cell_in;
   logic [2:0] nbr_idx_ff, nbr_idx_in;

   logic       rsp_strobe_ff, rsp_strobe_in;
   kind_type   rsp_kind_ff, rsp_kind_in;
   coord_type  rsp_x_ff, rsp_x_in;
   coord_type  rsp_y_ff, rsp_y_in;
   coord_type  rsp_z_ff, rsp_z_in;
   logic       rsp_flag_ff, rsp_flag_in;
   status_type rsp_status_ff, rsp_status_in;
   logic       rsp_last_ff, rsp_last_in;

   logic       mem_we;
   addr_type   mem_addr;
   cell_type   mem_wdata;
   cell_type   mem_rdata;

   nbr_type    nbr;
   upd_type    upd;
   logic       accept;
   logic       in_range;
   logic       adding;

   vhnt_cell_ram #(
      .ADDR_W (ADDR_W),
      .DATA_W (CELL_W)
   ) u_ram (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   vhnt_step_unit u_step (
      .base_x  (x_ff),
      .base_y  (y_ff),
      .base_z  (z_ff),
      .nbr_idx (nbr_idx_ff),
      .adding  (adding),
      .cell_in (mem_rdata),
      .nbr     (nbr),
      .upd     (upd)
   );

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign adding   = (func_ff == FUNC_ADD);
   assign in_range = ({3'b000, req_pos_x} < DIM_X) && ({3'b000, req_pos_y} < DIM_Y) &&
                     ({3'b000, req_pos_z} < DIM_Z);

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      func_in       = func_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      z_in          = z_ff;
      status_in     = status_ff;
      self_cell_in  = self_cell_ff;
      nbr_idx_in    = nbr_idx_ff;
      rsp_strobe_in = 1'b0;
      rsp_kind_in   = rsp_kind_ff;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_z_in      = rsp_z_ff;
      rsp_flag_in   = rsp_flag_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      mem_we        = 1'b0;
      mem_addr      = cell_addr(x_ff, y_ff, z_ff);
      mem_wdata     = mem_rdata;

      unique case (state_ff)
         ST_CLEAR: begin
            // sweep the store to zero, one cell a cycle
            mem_we      = 1'b1;
            mem_addr    = clr_addr_ff;
            mem_wdata   = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               func_in    = func_type'(req_func);
               x_in       = req_pos_x;
               y_in       = req_pos_y;
               z_in       = req_pos_z;
               status_in  = STAT_OK;
               nbr_idx_in = '0;
               if (!in_range) begin
                  status_in = STAT_RANGE;
                  state_in  = ST_DONE;
               end else if (func_type'(req_func) == FUNC_NOP) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SELF_RD;
               end
            end
         end
         ST_SELF_RD: begin
            // read of the voxel's own cell issued here
            state_in = ST_SELF_EVAL;
         end
         ST_SELF_EVAL: begin
            self_cell_in = mem_rdata;
            unique case (func_ff)
               FUNC_QUERY: begin
                  rsp_strobe_in = 1'b1;
                  rsp_kind_in   = KIND_QUERY;
                  rsp_x_in      = x_ff;
                  rsp_y_in      = y_ff;
                  rsp_z_in      = z_ff;
                  rsp_flag_in   = (mem_rdata[2:0] < FULL_CNT);
                  rsp_status_in = STAT_OK;
                  rsp_last_in   = 1'b0;
                  state_in      = ST_DONE;
               end
               FUNC_ADD: begin
                  if (mem_rdata[3]) begin
                     status_in = STAT_ALREADY;
                     state_in  = ST_DONE;
                  end else begin
                     mem_we    = 1'b1;
                     mem_wdata = {1'b1, mem_rdata[2:0]};
                     state_in  = ST_NB_RD;
                  end
               end
               FUNC_REMOVE: begin
                  if (!mem_rdata[3]) begin
                     status_in = STAT_NOT_SET;
                     state_in  = ST_DONE;
                  end else begin
                     mem_we    = 1'b1;
                     mem_wdata = {1'b0, mem_rdata[2:0]};
                     state_in  = ST_NB_RD;
                  end
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_NB_RD: begin
            mem_addr = cell_addr(nbr.x, nbr.y, nbr.z);
            if (nbr.in_grid) begin
               state_in = ST_NB_WB;
            end else if (nbr_idx_ff == LAST_NBR) begin
               // skip a face on the grid edge; its border cell is never set
               state_in = adding ? ST_SELF_HULL : ST_DONE;
            end else begin
               nbr_idx_in = nbr_idx_ff + 3'd1;
            end
         end
         ST_NB_WB: begin
            mem_we    = 1'b1;
            mem_addr  = cell_addr(nbr.x, nbr.y, nbr.z);
            mem_wdata = upd.new_cell;
            if (upd.report) begin
               rsp_strobe_in = 1'b1;
               rsp_kind_in   = upd.kind;
               rsp_x_in      = nbr.x;
               rsp_y_in      = nbr.y;
               rsp_z_in      = nbr.z;
               rsp_flag_in   = 1'b0;
               rsp_status_in = STAT_OK;
               rsp_last_in   = 1'b0;
            end
            if (nbr_idx_ff == LAST_NBR) begin
               state_in = adding ? ST_SELF_HULL : ST_DONE;
            end else begin
               nbr_idx_in = nbr_idx_ff + 3'd1;
               state_in   = ST_NB_RD;
            end
         end
         ST_SELF_HULL: begin
            // own count is untouched by the neighbor pass
            if (self_cell_ff[2:0] < FULL_CNT) begin
               rsp_strobe_in = 1'b1;
               rsp_kind_in   = KIND_HULL;
               rsp_x_in      = x_ff;
               rsp_y_in      = y_ff;
               rsp_z_in      = z_ff;
               rsp_flag_in   = 1'b0;
               rsp_status_in = STAT_OK;
               rsp_last_in   = 1'b0;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            rsp_strobe_in = 1'b1;
            rsp_kind_in   = KIND_DONE;
            rsp_x_in      = x_ff;
            rsp_y_in      = y_ff;
            rsp_z_in      = z_ff;
            rsp_flag_in   = 1'b0;
            rsp_status_in = status_ff;
            rsp_last_in   = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_addr_ff   <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      func_ff       <= func_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      z_ff          <= z_in;
      status_ff     <= status_in;
      self_cell_ff  <= self_cell_in;
      nbr_idx_ff    <= nbr_idx_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_z_ff      <= rsp_z_in;
      rsp_flag_ff   <= rsp_flag_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_out_x     = rsp_x_ff;
   assign rsp_out_y     = rsp_y_ff;
   assign rsp_out_z     = rsp_z_ff;
   assign rsp_hull_flag = rsp_flag_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_last      = rsp_last_ff;

   // no result may leave while the store is being cleared
   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !rsp_strobe_ff)
      else $error("result strobe during clearing pass");

   // write-back only touches a neighbor in the grid
   a_wb_in_grid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_NB_WB) |-> (nbr.in_grid && nbr_idx_ff <= LAST_NBR))
      else $error("write-back to a border cell");

   // an accepted item leaves idle on the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != ST_IDLE))
      else $error("accepted item did not start");

   // the done result is the one that closes the item and returns to idle
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_last_ff) |-> (rsp_kind_ff == KIND_DONE && $past(state_ff) == ST_DONE))
      else $error("last flag on a result other than done");

   // obscured results only come from neighbor write-back
   a_obsc_src: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_kind_ff == KIND_OBSC) |-> ($past(state_ff) == ST_NB_WB))
      else $error("obscured report outside neighbor pass");

endmodule
